/* design/lfd_pkg.sv */
package lfd_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int DELAY_CFG_W = 18;
  localparam int PHASE_W     = 32;
  localparam int GAIN_W      = 16;
  localparam int FRAC_W      = 8;
  localparam int SINE_W      = 15;
  localparam int LFO_W       = 16;
  localparam int PROD_W      = DELAY_CFG_W + LFO_W;
  localparam int SUM_W       = 20;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  localparam longint Q30 = 64'sd1073741824;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_BASE_DELAY     = 3'd0,
    REG_SWEEP_DEPTH    = 3'd1,
    REG_LFO_PHASE_STEP = 3'd2,
    REG_MIX_GAIN       = 3'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [DELAY_CFG_W-1:0] base_delay;
    logic [DELAY_CFG_W-1:0] sweep_depth;
    logic [PHASE_W-1:0]     lfo_phase_step;
    logic [GAIN_W-1:0]      mix_gain;
  } cfg_regs_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SINE,
    ST_LFO,
    ST_DELAY,
    ST_RD_A,
    ST_RD_B,
    ST_INTERP,
    ST_GAIN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic take;
    logic sine;
    logic lfo;
    logic delay;
    logic rd_a;
    logic rd_b;
    logic interp;
    logic gain;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

  // q15 quarter-wave sine entry, table of 2**tlog steps per quadrant
  function automatic int quarter_sine(input int k, input int tlog);
    longint x;
    longint x2;
    longint p;
    longint s;
    longint r;
    if (k >= (1 << tlog)) begin
      return 32767;
    end
    x  = (longint'(k) << 30) >>> tlog;
    x2 = (x * x) / Q30;
    p  = 64'sd172272;
    p  = -64'sd5026995 + (p * x2) / Q30;
    p  = 64'sd85569306 + (p * x2) / Q30;
    p  = -64'sd693598668 + (p * x2) / Q30;
    p  = 64'sd1686629713 + (p * x2) / Q30;
    s  = (p * x) / Q30;
    if (s < 0) begin
      s = 0;
    end
    r = (s + 16384) / 32768;
    if (r > 32767) begin
      r = 32767;
    end
    return int'(r);
  endfunction

endpackage

/* design/lfd_in_if.sv */
interface lfd_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [lfd_pkg::SAMPLE_W-1:0] in_sample;

  modport source (output valid, output in_sample, input ready);
  modport sink (input valid, input in_sample, output ready);
endinterface

/* design/lfd_out_if.sv */
interface lfd_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [lfd_pkg::SAMPLE_W-1:0] out_sample;

  modport source (output valid, output out_sample, input ready);
  modport sink (input valid, input out_sample, output ready);
endinterface

/* design/lfd_cfg_if.sv */
interface lfd_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [lfd_pkg::CFG_INDEX_W-1:0]     index;
  logic [lfd_pkg::CFG_DATA_W-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* design/lfd_cfg.sv */
module lfd_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_valid,
  output logic                             wr_ready,
  input  logic [lfd_pkg::CFG_INDEX_W-1:0]  wr_index,
  input  logic [lfd_pkg::CFG_DATA_W-1:0]   wr_data,
  output lfd_pkg::cfg_regs_t               regs
);
  import lfd_pkg::*;

  assign wr_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.base_delay     <= DELAY_CFG_W'(56448);
      regs.sweep_depth    <= DELAY_CFG_W'(56448);
      regs.lfo_phase_step <= PHASE_W'(16232);
      regs.mix_gain       <= GAIN_W'(16384);
    end else if (wr_valid) begin
      unique case (cfg_reg_t'(wr_index))
        REG_BASE_DELAY:     regs.base_delay     <= wr_data[DELAY_CFG_W-1:0];
        REG_SWEEP_DEPTH:    regs.sweep_depth    <= wr_data[DELAY_CFG_W-1:0];
        REG_LFO_PHASE_STEP: regs.lfo_phase_step <= wr_data[PHASE_W-1:0];
        REG_MIX_GAIN:       regs.mix_gain       <= wr_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end
endmodule

/* design/lfd_ctrl.sv */
module lfd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  lfd_pkg::dp_status_t status,
  output lfd_pkg::dp_cmd_t    cmd
);
  import lfd_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = ST_SINE;
        end
      end
      ST_SINE: begin
        cmd.sine   = 1'b1;
        state_next = ST_LFO;
      end
      ST_LFO: begin
        cmd.lfo    = 1'b1;
        state_next = ST_DELAY;
      end
      ST_DELAY: begin
        cmd.delay  = 1'b1;
        state_next = ST_RD_A;
      end
      ST_RD_A: begin
        cmd.rd_a   = 1'b1;
        state_next = ST_RD_B;
      end
      ST_RD_B: begin
        cmd.rd_b   = 1'b1;
        state_next = ST_INTERP;
      end
      ST_INTERP: begin
        cmd.interp = 1'b1;
        state_next = ST_GAIN;
      end
      ST_GAIN: begin
        cmd.gain   = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end
endmodule

/* design/lfd_dpath.sv */
module lfd_dpath #(
  parameter int DELAY_DEPTH      = 4096,
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  input  lfd_pkg::dp_cmd_t                    cmd,
  output lfd_pkg::dp_status_t                 status,
  input  lfd_pkg::cfg_regs_t                  cfg,
  input  logic signed [lfd_pkg::SAMPLE_W-1:0] in_sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [lfd_pkg::SAMPLE_W-1:0] out_sample
);
  import lfd_pkg::*;

  localparam int AW  = $clog2(DELAY_DEPTH);
  localparam int TW  = $clog2(SINE_TABLE_DEPTH);
  localparam int DW  = AW + FRAC_W;
  localparam int CW  = (DW > SUM_W) ? DW : SUM_W;
  localparam int CAP = (DELAY_DEPTH - 2) * 256;
  localparam int IW  = 26;
  localparam int WPW = IW + GAIN_W + 1;
  localparam int WW  = WPW - 23;

  logic [SINE_W-1:0] rom [SINE_TABLE_DEPTH+1];

  for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_rom
    assign rom[g] = SINE_W'(quarter_sine(g, TW));
  end

  logic signed [SAMPLE_W-1:0] mem [DELAY_DEPTH];

  logic signed [SAMPLE_W-1:0] x_q;
  logic [PHASE_W-1:0]         phase;
  logic [AW-1:0]              wp;
  logic                       wrapped;
  logic [1:0]                 quad_q;
  logic [SINE_W-1:0]          sine_q;
  logic [PROD_W-1:0]          prod_q;
  logic [AW-1:0]              dly_d;
  logic [FRAC_W-1:0]          dly_f;
  logic signed [SAMPLE_W-1:0] rdata;
  logic                       rd_ok;
  logic signed [SAMPLE_W-1:0] a_q;
  logic signed [IW-1:0]       interp_q;
  logic signed [WPW-1:0]      wet_prod_q;

  logic [1:0]         quad;
  logic [TW-1:0]      tab_k;
  logic [TW:0]        rom_addr;
  logic [LFO_W-1:0]   lfo;
  logic [CW-1:0]      sum_w;
  logic [CW-1:0]      dly_cl;
  logic [AW-1:0]      rd_addr;
  logic signed [SAMPLE_W-1:0] b_val;
  logic [FRAC_W:0]    f_inv;
  logic signed [WW-1:0]  wet;
  logic signed [WW:0]    y;
  logic signed [SAMPLE_W-1:0] y_sat;

  assign quad     = phase[PHASE_W-1 -: 2];
  assign tab_k    = phase[PHASE_W-3 -: TW];
  assign rom_addr = quad[0] ? (TW+1)'(SINE_TABLE_DEPTH) - {1'b0, tab_k} : {1'b0, tab_k};

  assign lfo = quad_q[1] ? LFO_W'(17'd32768 - 17'(sine_q))
                         : LFO_W'(17'd32768 + 17'(sine_q));

  assign sum_w  = CW'(cfg.base_delay) + CW'(prod_q[PROD_W-1:15]);
  assign dly_cl = (sum_w > CW'(CAP)) ? CW'(CAP) : sum_w;

  assign rd_addr = cmd.rd_b ? wp - dly_d - AW'(1) : wp - dly_d;
  assign b_val   = rd_ok ? rdata : '0;
  assign f_inv   = (FRAC_W+1)'(256) - {1'b0, dly_f};

  assign wet = WW'((wet_prod_q + WPW'(64'sd4194304)) >>> 23);
  assign y   = (WW+1)'(x_q) + (WW+1)'(wet);

  always_comb begin
    if (y > (WW+1)'(32767)) begin
      y_sat = 16'sh7FFF;
    end else if (y < -(WW+1)'(32768)) begin
      y_sat = -16'sh8000;
    end else begin
      y_sat = y[SAMPLE_W-1:0];
    end
  end

  assign status.out_free = !out_valid || out_ready;

  // delay memory, one write and one read port
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      mem[wp] <= in_sample;
    end
    if (cmd.rd_a || cmd.rd_b) begin
      rdata <= mem[rd_addr];
      rd_ok <= wrapped || (rd_addr <= wp);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= '0;
      wp        <= '0;
      wrapped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.take) begin
        phase <= phase + cfg.lfo_phase_step;
      end
      if (cmd.load_out) begin
        wp        <= wp + AW'(1);
        out_valid <= 1'b1;
        if (wp == '1) begin
          wrapped <= 1'b1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      x_q <= in_sample;
    end
    if (cmd.sine) begin
      sine_q <= rom[rom_addr];
      quad_q <= quad;
    end
    if (cmd.lfo) begin
      prod_q <= PROD_W'(cfg.sweep_depth) * PROD_W'(lfo);
    end
    if (cmd.delay) begin
      dly_d <= dly_cl[DW-1:FRAC_W];
      dly_f <= dly_cl[FRAC_W-1:0];
    end
    if (cmd.rd_b) begin
      a_q <= rd_ok ? rdata : '0;
    end
    if (cmd.interp) begin
      interp_q <= a_q * $signed({1'b0, f_inv}) + b_val * $signed({1'b0, dly_f});
    end
    if (cmd.gain) begin
      wet_prod_q <= interp_q * $signed({1'b0, cfg.mix_gain});
    end
    if (cmd.load_out) begin
      out_sample <= y_sat;
    end
  end
endmodule

/* design/lfo_flanger_delay_line.sv */
// Mono flanger: each sample goes into a circular delay line, a sine lfo sweeps
// the tap position and two neighboring taps are interpolated, scaled by mix_gain
// and added to the dry sample with 16-bit saturation. One sample is in flight at
// a time; from its transaction to its result register a sample passes the sine
// rom read, sweep multiply, delay clamp, then the two taps read one after the
// other through the single read port of the delay memory, then interpolation,
// gain and the saturating add into the result register. The next sample is taken
// only back in the idle state, so no new sample is accepted before the last one
// reaches the result register. A finished result waits in the output register
// while the next sample is accepted; a result still waiting when the next one is
// done holds the block until it is taken. The delay memory needs no clearing pass
// after reset: a write-wrap flag makes taps that were never written read as zero.
module lfo_flanger_delay_line #(
  parameter int DELAY_DEPTH      = 4096,
  parameter int SINE_TABLE_DEPTH = 256
) (
  input logic           clk,
  input logic           rst,
  lfd_in_if.sink        sample_ch,
  lfd_out_if.source     result_ch,
  lfd_cfg_if.sink       cfg
);
  import lfd_pkg::*;

  cfg_regs_t  regs;
  dp_cmd_t    cmd;
  dp_status_t status;

  lfd_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (cfg.valid),
    .wr_ready (cfg.ready),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .regs     (regs)
  );

  lfd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample_ch.valid),
    .in_ready (sample_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  lfd_dpath #(
    .DELAY_DEPTH      (DELAY_DEPTH),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .cfg        (regs),
    .in_sample  (sample_ch.in_sample),
    .out_valid  (result_ch.valid),
    .out_ready  (result_ch.ready),
    .out_sample (result_ch.out_sample)
  );
endmodule

/* bench/lfo_flanger_delay_line_test.sv */
`timescale 1ns / 100ps

module lfo_flanger_delay_line_test;
  import lfd_pkg::*;

  localparam int DELAY_DEPTH      = 4096;
  localparam int SINE_TABLE_DEPTH = 256;
  localparam int PTR_W            = $clog2(DELAY_DEPTH);
  localparam int SINE_STEPS       = $clog2(SINE_TABLE_DEPTH);
  localparam int FIRST_UNUSED_REG = REG_MIX_GAIN + 1;
  localparam int LAST_REG_INDEX   = (1 << CFG_INDEX_W) - 1;
  localparam int RANDOM_PHASES    = 10;
  localparam int ITEMS_PER_PHASE  = 103;
  localparam int DRAIN_CYCLES     = 40;
  localparam int CYCLE_LIMIT      = 400000;
  localparam int MAX_REPORTS      = 100;
  localparam longint ONE_Q30      = 64'sd1073741824;
  localparam longint DELAY_CAP    = longint'(DELAY_DEPTH - 2) << FRAC_W;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lfd_in_if  sample_if ();
  lfd_out_if result_if ();
  lfd_cfg_if cfg_if ();

  lfo_flanger_delay_line #(
    .DELAY_DEPTH      (DELAY_DEPTH),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .sample_ch (sample_if),
    .result_ch (result_if),
    .cfg       (cfg_if)
  );

  // predicted state of the flanger
  logic signed [SAMPLE_W-1:0] tap_line [DELAY_DEPTH];
  logic [PTR_W-1:0]           tap_wr;
  logic [PHASE_W-1:0]         lfo_acc;
  logic [DELAY_CFG_W-1:0]     cur_base_delay;
  logic [DELAY_CFG_W-1:0]     cur_sweep;
  logic [PHASE_W-1:0]         cur_step;
  logic [GAIN_W-1:0]          cur_gain;
  int                         sine_rom [SINE_TABLE_DEPTH + 1];

  logic signed [SAMPLE_W-1:0] pending_samples [$];
  logic signed [SAMPLE_W-1:0] expected_out [$];
  logic signed [SAMPLE_W-1:0] want;

  int error_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int gap_left = 0;
  int stall_left = 0;
  bit sample_done = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int sine_q15_entry(input int k);
    longint x, x2, poly, s, r;
    if (k >= SINE_TABLE_DEPTH) return 32767;
    x    = (longint'(k) * ONE_Q30) / SINE_TABLE_DEPTH;
    x2   = (x * x) / ONE_Q30;
    poly = 64'sd172272;
    poly = -64'sd5026995 + (poly * x2) / ONE_Q30;
    poly = 64'sd85569306 + (poly * x2) / ONE_Q30;
    poly = -64'sd693598668 + (poly * x2) / ONE_Q30;
    poly = 64'sd1686629713 + (poly * x2) / ONE_Q30;
    s    = (poly * x) / ONE_Q30;
    if (s < 0) s = 0;
    r = (s + 16384) / 32768;
    return (r > 32767) ? 32767 : int'(r);
  endfunction

  // advances the lfo, stores the dry sample and returns dry plus scaled wet
  function automatic logic signed [SAMPLE_W-1:0] flange_sample(
    input logic signed [SAMPLE_W-1:0] dry
  );
    logic [SINE_STEPS+1:0] pos;
    logic [PTR_W-1:0]      near_idx;
    logic [PTR_W-1:0]      far_idx;
    int                    k, sn, whole, frac;
    longint                tap_delay, mix, wet, sum;
    lfo_acc = lfo_acc + cur_step;
    pos = lfo_acc[PHASE_W-1 -: SINE_STEPS+2];
    k = int'(pos[SINE_STEPS-1:0]);
    if (pos[SINE_STEPS]) k = SINE_TABLE_DEPTH - k;
    sn = pos[SINE_STEPS+1] ? -sine_rom[k] : sine_rom[k];
    tap_delay = longint'(cur_base_delay) +
                ((longint'(cur_sweep) * longint'(sn + 32768)) >>> SINE_W);
    if (tap_delay > DELAY_CAP) tap_delay = DELAY_CAP;
    whole = int'(tap_delay >>> FRAC_W);
    frac  = int'(tap_delay[FRAC_W-1:0]);
    tap_line[tap_wr] = dry;
    near_idx = tap_wr - PTR_W'(whole);
    far_idx  = near_idx - PTR_W'(1);
    mix = longint'(tap_line[near_idx]) * ((1 << FRAC_W) - frac) +
          longint'(tap_line[far_idx]) * frac;
    wet = (mix * longint'(cur_gain) + (64'sd1 <<< 22)) >>> 23;
    sum = longint'(dry) + wet;
    tap_wr = tap_wr + PTR_W'(1);
    if (sum > 32767) return 16'sh7FFF;
    if (sum < -32768) return 16'sh8000;
    return SAMPLE_W'(sum);
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2, 3: return SAMPLE_W'($urandom_range(0, 1023) - 512);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // upper bits are random so that masking to the register width is exercised
  function automatic logic [CFG_DATA_W-1:0] pick_delay();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return $urandom;
      default: return ($urandom & ~32'h3FFFF) | $urandom_range(0, 80 << FRAC_W);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_step();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return $urandom;
      3: return $urandom_range(1, 1 << 24);
      default: return $urandom_range(1 << 24, 1 << 28);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_gain();
    case ($urandom_range(0, 6))
      0: return '0;
      1: return 32'd32768;
      2: return '1;
      3: return $urandom;
      default: return ($urandom & ~32'hFFFF) | $urandom_range(0, 32768);
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      REG_BASE_DELAY:     cur_base_delay = value[DELAY_CFG_W-1:0];
      REG_SWEEP_DEPTH:    cur_sweep      = value[DELAY_CFG_W-1:0];
      REG_LFO_PHASE_STEP: cur_step       = value[PHASE_W-1:0];
      REG_MIX_GAIN:       cur_gain       = value[GAIN_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_samples.size() != 0 || expected_out.size() != 0 || sample_if.valid);
  endtask

  // sample driver
  always @(negedge clk) begin
    if (rst) begin
      sample_if.valid <= 1'b0;
      gap_left = 0;
    end else if (!sample_if.valid || sample_done) begin
      sample_done = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        sample_if.valid <= 1'b0;
      end else if (send_idle_pct != 0 && $urandom_range(1, 100) <= send_idle_pct) begin
        gap_left = $urandom_range(0, 4);
        sample_if.valid <= 1'b0;
      end else if (pending_samples.size() != 0) begin
        sample_if.valid     <= 1'b1;
        sample_if.in_sample <= pending_samples.pop_front();
      end else begin
        sample_if.valid <= 1'b0;
      end
    end
  end

  // result sink
  always @(negedge clk) begin
    if (rst) begin
      result_if.ready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      result_if.ready <= 1'b0;
    end else if (recv_idle_pct != 0 && $urandom_range(1, 100) <= recv_idle_pct) begin
      stall_left = $urandom_range(0, 4);
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= 1'b1;
    end
  end

  // monitor: predict on each input transaction, check each output transaction
  always @(posedge clk) begin
    if (!rst) begin
      if (sample_if.valid && sample_if.ready) begin
        sample_done = 1'b1;
        expected_out.push_back(flange_sample(sample_if.in_sample));
      end
      if (result_if.valid && result_if.ready) begin
        if (expected_out.size() == 0) begin
          report_mismatch($sformatf("out_sample %0d with no sample outstanding",
                                    result_if.out_sample));
        end else begin
          want = expected_out.pop_front();
          if (result_if.out_sample !== want)
            report_mismatch($sformatf("out_sample %0d, expected %0d",
                                      result_if.out_sample, want));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    logic [SAMPLE_W-1:0] reset_corners [8];
    reset_corners = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF,
                      16'h0001, 16'h7FFF, 16'h7FFF, 16'h8000};
    sample_if.valid     = 1'b0;
    sample_if.in_sample = '0;
    result_if.ready     = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = REG_BASE_DELAY;
    cfg_if.data         = '0;
    foreach (tap_line[i]) tap_line[i] = '0;
    foreach (sine_rom[i]) sine_rom[i] = sine_q15_entry(i);
    tap_wr         = '0;
    lfo_acc        = '0;
    cur_base_delay = 18'd56448;
    cur_sweep      = 18'd56448;
    cur_step       = 32'd16232;
    cur_gain       = 16'd16384;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // register values after reset, full-scale and near-zero samples
    send_idle_pct = 30;
    recv_idle_pct = 30;
    foreach (reset_corners[i]) pending_samples.push_back(reset_corners[i]);
    wait_drained();

    // zero delay at unity gain: the tap is the sample just written
    write_reg(REG_BASE_DELAY, '0);
    write_reg(REG_SWEEP_DEPTH, '0);
    write_reg(REG_MIX_GAIN, 32'd32768);
    pending_samples.push_back(16'sd20000);
    pending_samples.push_back(-16'sd20000);
    pending_samples.push_back(16'sh7FFF);
    pending_samples.push_back(16'sh8000);
    pending_samples.push_back(16'sd5);
    wait_drained();

    // gain above unity with overflow, and an ignored register index
    write_reg(REG_BASE_DELAY, 32'd1 << FRAC_W);
    write_reg(REG_MIX_GAIN, '1);
    write_reg(CFG_INDEX_W'(FIRST_UNUSED_REG), '1);
    pending_samples.push_back(16'sd30000);
    pending_samples.push_back(16'sd30000);
    pending_samples.push_back(-16'sd30000);
    pending_samples.push_back(-16'sd30000);
    pending_samples.push_back(16'sd1000);
    wait_drained();

    // largest delay settings, which still stay below the cap, zero gain
    write_reg(REG_BASE_DELAY, '1);
    write_reg(REG_SWEEP_DEPTH, '1);
    write_reg(REG_LFO_PHASE_STEP, '1);
    write_reg(REG_MIX_GAIN, '0);
    pending_samples.push_back(16'sh7FFF);
    pending_samples.push_back(16'sh8000);
    pending_samples.push_back(16'sd1234);
    wait_drained();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_reg(REG_BASE_DELAY, pick_delay());
      write_reg(REG_SWEEP_DEPTH, pick_delay());
      write_reg(REG_LFO_PHASE_STEP, pick_step());
      write_reg(REG_MIX_GAIN, pick_gain());
      if ($urandom_range(0, 3) == 0)
        write_reg(CFG_INDEX_W'($urandom_range(FIRST_UNUSED_REG, LAST_REG_INDEX)), $urandom);
      if (p == RANDOM_PHASES - 1) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else begin
        send_idle_pct = 20 * $urandom_range(0, 2);
        recv_idle_pct = 20 * $urandom_range(0, 2);
      end
      repeat (ITEMS_PER_PHASE) pending_samples.push_back(pick_sample());
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* lfo_flanger_delay_line.f */
design/lfd_pkg.sv
design/lfd_in_if.sv
design/lfd_out_if.sv
design/lfd_cfg_if.sv
design/lfd_cfg.sv
design/lfd_ctrl.sv
design/lfd_dpath.sv
design/lfo_flanger_delay_line.sv
bench/lfo_flanger_delay_line_test.sv
